>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the console writer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each clock edge, masked while reset is held.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on each clock edge, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/core/tccw_pkg.sv
// Shared types, codes and defaults of the text console character writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    localparam int POS_W           = 11;
    localparam int ENTRY_W         = 16;
    localparam int COLOR_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int KIND_W          = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 40;
    localparam int LIN_W           = 16;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;
    localparam int DEFAULT_QDEPTH  = 4;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    localparam logic REQ_PUT   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NULL      = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [KIND_W-1:0] KIND_CELL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Command opcodes handed from front to back
    localparam logic [1:0] OP_CHAR   = 2'd0;
    localparam logic [1:0] OP_CURSOR = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [POS_W-1:0]   addr;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   pos;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/core/tccw_front.sv
// Front end: takes request beats and config writes, tracks the cursor,
// builds one command per request other than a null character. Depends on tccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccw_front
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COLOR_W-1:0]    cfg_data,
    input  wire q_status_t             q_status,
    output      logic                  push,
    output      cmd_t                  push_cmd
);

    localparam int COL_W = $clog2(COLUMNS + 1);
    localparam int ROW_W = $clog2(ROWS);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;

    logic               accept;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [ROW_W-1:0]   row_inc;
    logic [CHAR_W-1:0]  entry_char;
    logic [1:0]         op;
    logic               bump;
    logic [LIN_W-1:0]   lin;
    logic [LIN_W-1:0]   pos_lin;

    assign s_tready  = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FG:  fg_next = cfg_data;
                CFG_BG:  bg_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        row_inc    = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
        col_next   = col_reg;
        row_next   = row_reg;
        cell_col   = col_reg;
        cell_row   = row_reg;
        entry_char = s_tdata;
        op         = OP_CURSOR;
        bump       = 1'b0;
        push       = 1'b0;
        if (accept) begin
            if (s_tuser == REQ_CLEAR) begin
                col_next   = '0;
                row_next   = '0;
                op         = OP_CLEAR;
                entry_char = CH_SPACE;
                push       = 1'b1;
            end else begin
                case (s_tdata)
                    CH_NULL: ;
                    CH_BACKSPACE: begin
                        if (col_reg != '0) begin
                            cell_col = col_reg - 1'b1;
                        end else if (row_reg != '0) begin
                            cell_row = row_reg - 1'b1;
                            cell_col = COL_W'(COLUMNS - 1);
                        end
                        col_next   = cell_col;
                        row_next   = cell_row;
                        op         = OP_CHAR;
                        entry_char = CH_SPACE;
                        push       = 1'b1;
                    end
                    CH_NEWLINE: begin
                        cell_col = '0;
                        cell_row = row_inc;
                        col_next = cell_col;
                        row_next = cell_row;
                        op       = OP_CURSOR;
                        push     = 1'b1;
                    end
                    default: begin
                        // wrap to the next row before writing
                        if (col_reg >= COL_W'(COLUMNS)) begin
                            cell_col = '0;
                            cell_row = row_inc;
                        end
                        col_next = cell_col + 1'b1;
                        row_next = cell_row;
                        bump     = 1'b1;
                        op       = OP_CHAR;
                        push     = 1'b1;
                    end
                endcase
            end
        end
        lin     = LIN_W'(cell_row) * LIN_W'(COLUMNS) + LIN_W'(cell_col);
        pos_lin = lin + LIN_W'(bump);
    end

    always_comb begin
        push_cmd.op    = op;
        push_cmd.addr  = (op == OP_CHAR) ? lin[POS_W-1:0] : '0;
        push_cmd.entry = {bg_reg, fg_reg, entry_char};
        push_cmd.pos   = (op == OP_CLEAR) ? '0 : pos_lin[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            fg_reg  <= FG_RESET;
            bg_reg  <= BG_RESET;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            fg_reg  <= fg_next;
            bg_reg  <= bg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tccw_queue.sv
// Short register queue of commands between front and back.
// Depends on tccw_pkg for the command type and status struct.
`timescale 1ns / 1ps
`default_nettype none

module tccw_queue
    import tccw_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QDEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire cmd_t      push_cmd,
    input  wire logic      pop,
    output      cmd_t      head,
    output      q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign head         = slot_reg[rd_reg];
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tccw_back.sv
// Back end: expands queued commands into result beats held in an
// output register. Depends on tccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccw_back
    import tccw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 head,
    input  wire q_status_t            q_status,
    output      logic                 pop,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [M_TDATA_W-1:0] m_tdata,
    output      logic [KIND_W-1:0]    m_tuser,
    output      logic                 m_tlast
);

    logic               valid_reg, valid_next;
    logic               phase_reg, phase_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [POS_W-1:0]   addr_reg, addr_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               last_reg, last_next;

    logic load;
    logic final_beat;

    assign load = (!valid_reg || m_tready) && !q_status.empty;

    always_comb begin
        final_beat = 1'b1;
        kind_next  = KIND_CURSOR;
        addr_next  = '0;
        entry_next = '0;
        pos_next   = head.pos;
        last_next  = 1'b1;
        case (head.op)
            OP_CHAR: begin
                if (!phase_reg) begin
                    final_beat = 1'b0;
                    kind_next  = KIND_CELL;
                    addr_next  = head.addr;
                    entry_next = head.entry;
                    pos_next   = '0;
                    last_next  = 1'b0;
                end
            end
            OP_CLEAR: begin
                kind_next  = KIND_CLEAR;
                entry_next = head.entry;
                pos_next   = '0;
            end
            default: ;
        endcase
        pop        = load && final_beat;
        phase_next = load ? !final_beat : phase_reg;
        valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            entry_reg <= entry_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_TDATA_W - 2 * POS_W - ENTRY_W)'(0), pos_reg, entry_reg, addr_reg};

endmodule

`default_nettype wire

>>> rtl/core/text_console_char_writer_top.sv
// Top level of the text console character writer: front, command queue, back.
// Depends on tccw_pkg, tccw_front, tccw_queue and tccw_back.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a text-screen cursor and turns each request beat into result beats:
// a printable character or backspace gives a cell write then a cursor update
// (two beats, tlast on the second), a newline gives a cursor update, a clear
// gives one clear-fill beat, and a null character gives nothing. Results
// leave through a one-beat output register at one beat per cycle while
// m_tready is high and commands are queued; the first result beat of a
// request passes through the command queue and then the output register.
// A command queue of QUEUE_DEPTH entries (four by default) lets the input
// keep going while results are stalled. Color writes on the config port
// apply to requests taken afterwards and are always ready.
module text_console_char_writer_top
    import tccw_pkg::*;
#(
    parameter int COLUMNS     = DEFAULT_COLUMNS,
    parameter int ROWS        = DEFAULT_ROWS,
    parameter int QUEUE_DEPTH = DEFAULT_QDEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_code
    input  wire logic                 s_tuser,   // [0] req_type
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [M_TDATA_W-1:0] m_tdata,   // [10:0] cell_address,
                                                 // [26:11] cell_entry,
                                                 // [37:27] cursor_position
    output      logic [KIND_W-1:0]    m_tuser,   // [1:0] result_kind
    output      logic                 m_tlast,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tccw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    tccw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/tccw_checker.sv
// Port-level checks on the result channel of the console writer, bound to
// the top level. Depends on tccw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tccw_checker
    import tccw_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]    m_tuser,
    input wire logic                 m_tlast
);

    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "valid after reset")

    `ASSERT_CLKD(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")

    `ASSERT_CLKD(a_cell_not_last, aclk, aresetn, m_tvalid && m_tuser == KIND_CELL |-> !m_tlast, "cell write beat marked last")

    `ASSERT_CLKD(a_cell_then_cursor, aclk, aresetn, m_tvalid && m_tready && m_tuser == KIND_CELL |=> m_tvalid && m_tuser == KIND_CURSOR && m_tlast, "cell write not followed by cursor update")

    `ASSERT_CLKD(a_clear_shape, aclk, aresetn, m_tvalid && m_tuser == KIND_CLEAR |-> m_tlast && m_tdata[10:0] == 11'd0 && m_tdata[37:27] == 11'd0, "clear beat malformed")

endmodule

bind text_console_char_writer_top tccw_checker u_chk (.*);

`default_nettype wire
